// ----- rtl/drn_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, widths and arithmetic helpers for the dead reckoning navigator.
// Used by every module of the block; it depends on nothing else.
package drn_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int ATAN_W = 5;

	localparam int MW = 40;
	localparam int WW = 2 * MW;
	localparam int NW = 64;
	localparam int DW = 32;
	localparam int AW = 36;

	localparam logic signed [AW-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [AW-1:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [AW-1:0] CORDIC_GAIN = 36'sd652032874;

	localparam logic [DW-1:0] TWO_PI_Q28 = 32'd1686629713;
	localparam logic [DW-1:0] DIV_MS = 32'd1000;
	localparam logic [DW-1:0] DIV_TRAP = 32'd2000;
	localparam logic signed [WW-1:0] HALF_MS = 80'sd500;
	localparam logic signed [WW-1:0] HALF_TRAP = 80'sd1000;
	localparam logic signed [WW-1:0] SEC_NUM = 80'sd70368744177664;

	function automatic logic [31:0] atan_lut(input logic [ATAN_W-1:0] i);
		case (i)
			5'd0: atan_lut = 32'h3243F6A8;
			5'd1: atan_lut = 32'h1DAC6705;
			5'd2: atan_lut = 32'h0FADBAFC;
			5'd3: atan_lut = 32'h07F56EA6;
			5'd4: atan_lut = 32'h03FEAB76;
			5'd5: atan_lut = 32'h01FFD55B;
			5'd6: atan_lut = 32'h00FFFAAA;
			5'd7: atan_lut = 32'h007FFF55;
			5'd8: atan_lut = 32'h003FFFEA;
			5'd9: atan_lut = 32'h001FFFFD;
			5'd10: atan_lut = 32'h000FFFFF;
			5'd11: atan_lut = 32'h0007FFFF;
			5'd12: atan_lut = 32'h0003FFFF;
			5'd13: atan_lut = 32'h0001FFFF;
			5'd14: atan_lut = 32'h0000FFFF;
			5'd15: atan_lut = 32'h00007FFF;
			5'd16: atan_lut = 32'h00003FFF;
			5'd17: atan_lut = 32'h00001FFF;
			5'd18: atan_lut = 32'h00000FFF;
			5'd19: atan_lut = 32'h000007FF;
			5'd20: atan_lut = 32'h000003FF;
			5'd21: atan_lut = 32'h000001FF;
			5'd22: atan_lut = 32'h000000FF;
			5'd23: atan_lut = 32'h0000007F;
			5'd24: atan_lut = 32'h0000003F;
			5'd25: atan_lut = 32'h0000001F;
			5'd26: atan_lut = 32'h0000000F;
			5'd27: atan_lut = 32'h00000008;
			5'd28: atan_lut = 32'h00000004;
			5'd29: atan_lut = 32'h00000002;
			5'd30: atan_lut = 32'h00000001;
			default: atan_lut = 32'h00000000;
		endcase
	endfunction

	function automatic logic signed [WW-1:0] rshr(input logic signed [WW-1:0] v,
			input int unsigned s);
		logic signed [WW-1:0] half;
		half = WW'(1);
		half = half <<< (s - 1);
		rshr = (v + half) >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] v);
		if (v[WW-1:31] == '0 || v[WW-1:31] == '1) begin
			sat32 = v[31:0];
		end else if (v[WW-1]) begin
			sat32 = {1'b1, {31{1'b0}}};
		end else begin
			sat32 = {1'b0, {31{1'b1}}};
		end
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [WW-1:0] v);
		if (v[WW-1:47] == '0 || v[WW-1:47] == '1) begin
			sat48 = v[47:0];
		end else if (v[WW-1]) begin
			sat48 = {1'b1, {47{1'b0}}};
		end else begin
			sat48 = {1'b0, {47{1'b1}}};
		end
	endfunction

	function automatic logic signed [WW-1:0] floor_q(input logic [NW-1:0] q,
			input logic [DW-1:0] r, input logic neg);
		logic signed [WW-1:0] qq;
		qq = WW'(q);
		if (!neg) begin
			floor_q = qq;
		end else if (r != '0) begin
			floor_q = -qq - WW'(1);
		end else begin
			floor_q = -qq;
		end
	endfunction

endpackage

// ----- rtl/drn_if.sv -----
`timescale 1ns / 1ps
// Handshake channels of the navigator: sensor samples in, position fixes out.
// Stand-alone; no package is needed.
interface drn_sample_if;
	logic valid;
	logic ready;
	logic req_type;
	logic signed [31:0] speed;
	logic signed [31:0] accel_fwd;
	logic signed [31:0] accel_side;
	logic signed [31:0] rate_x;
	logic signed [31:0] rate_y;
	logic signed [31:0] rate_z;
	logic [15:0] dt_ms;
	modport source(output valid, req_type, speed, accel_fwd, accel_side, rate_x, rate_y,
		rate_z, dt_ms, input ready);
	modport sink(input valid, req_type, speed, accel_fwd, accel_side, rate_x, rate_y,
		rate_z, dt_ms, output ready);
endinterface

interface drn_fix_if;
	logic valid;
	logic ready;
	logic signed [47:0] north;
	logic signed [47:0] east;
	logic signed [31:0] heading;
	modport source(output valid, north, east, heading, input ready);
	modport sink(input valid, north, east, heading, output ready);
endinterface

// ----- rtl/drn_mul.sv -----
`timescale 1ns / 1ps
// Bit-serial signed multiplier: one multiplier bit per cycle.
// Depends on drn_pkg for the operand widths.
module drn_mul import drn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [MW-1:0] a,
	input  logic signed [MW-1:0] b,
	output logic signed [WW-1:0] p,
	output logic                 done
);
	localparam int CNT_W = $clog2(MW);

	logic signed [WW-1:0] mcand_q;
	logic signed [WW-1:0] acc_q;
	logic [MW-1:0] mplier_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic last;

	assign last = (cnt_q == CNT_W'(MW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcand_q <= '0;
			acc_q <= '0;
			mplier_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mcand_q <= WW'(a);
				mplier_q <= b;
				acc_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (mplier_q[0]) begin
					// The top bit of a two's complement multiplier carries negative weight.
					acc_q <= last ? acc_q - mcand_q : acc_q + mcand_q;
				end
				mcand_q <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign p = acc_q;
	assign done = done_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("multiplier done while still busy");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q && !last && !start |=> busy_q)
		else $error("multiplier stopped early");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q))
		else $error("multiplier done without a running product");
endmodule

// ----- rtl/drn_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider: one quotient bit per cycle.
// Depends on drn_pkg for the operand widths.
module drn_div import drn_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic [NW-1:0] q,
	output logic [DW-1:0] r,
	output logic          done
);
	localparam int CNT_W = $clog2(NW);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DW:0] trial;
	logic fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= n;
				den_q <= d;
				rem_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
				num_q <= {num_q[NW-2:0], fits};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign q = num_q;
	assign r = rem_q;
	assign done = done_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while still busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> rem_q < den_q)
		else $error("divider remainder not below divisor");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q))
		else $error("divider done without a running quotient");
endmodule

// ----- rtl/drn_cordic.sv -----
`timescale 1ns / 1ps
// Iterative rotation CORDIC: range reduction first, then one step a cycle.
// Depends on drn_pkg for the angle constants and the arctangent table.
module drn_cordic import drn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] angle,
	output logic signed [AW-1:0] cos_v,
	output logic signed [AW-1:0] sin_v,
	output logic                 done
);
	typedef enum logic [2:0] {
		C_IDLE,
		C_TURN,
		C_HALF,
		C_FOLD,
		C_ITER
	} cor_state_t;

	cor_state_t state_q;
	logic signed [AW-1:0] r_q;
	logic signed [AW-1:0] x_q;
	logic signed [AW-1:0] y_q;
	logic [STEP_W-1:0] i_q;
	logic neg_q;
	logic done_q;
	logic signed [AW-1:0] atan_v;
	logic signed [AW-1:0] xs;
	logic signed [AW-1:0] ys;

	assign atan_v = AW'(atan_lut(ATAN_W'(i_q)));
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			r_q <= '0;
			x_q <= '0;
			y_q <= '0;
			i_q <= '0;
			neg_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						r_q <= angle;
						state_q <= C_TURN;
					end
				end
				C_TURN: begin
					// Truncating remainder by a full turn; the input spans less than two.
					if (r_q >= TWO_PI_Q30) begin
						r_q <= r_q - TWO_PI_Q30;
					end else if (r_q <= -TWO_PI_Q30) begin
						r_q <= r_q + TWO_PI_Q30;
					end
					state_q <= C_HALF;
				end
				C_HALF: begin
					if (r_q >= PI_Q30) begin
						r_q <= r_q - TWO_PI_Q30;
					end else if (r_q < -PI_Q30) begin
						r_q <= r_q + TWO_PI_Q30;
					end
					state_q <= C_FOLD;
				end
				C_FOLD: begin
					neg_q <= 1'b0;
					if (r_q > HALF_PI_Q30) begin
						r_q <= r_q - PI_Q30;
						neg_q <= 1'b1;
					end else if (r_q < -HALF_PI_Q30) begin
						r_q <= r_q + PI_Q30;
						neg_q <= 1'b1;
					end
					x_q <= CORDIC_GAIN;
					y_q <= '0;
					i_q <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					if (!r_q[AW-1]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						r_q <= r_q - atan_v;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						r_q <= r_q + atan_v;
					end
					i_q <= i_q + STEP_W'(1);
					if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
						done_q <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign cos_v = neg_q ? -x_q : x_q;
	assign sin_v = neg_q ? -y_q : y_q;
	assign done = done_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> state_q == C_IDLE)
		else $error("rotation done outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
			state_q == C_ITER |-> r_q <= HALF_PI_Q30 && r_q >= -HALF_PI_Q30)
		else $error("residual angle outside a quarter turn");
	assert property (@(posedge clk) disable iff (!arst_n) $fell(state_q == C_ITER) |-> done_q)
		else $error("iterations ended without done");
endmodule

// ----- rtl/dead_reckoning_navigator_core.sv -----
`timescale 1ns / 1ps
// Top level of the dead reckoning navigator: sequencer, navigation state and output stage.
// Depends on drn_pkg, drn_if, drn_mul, drn_div and drn_cordic.
//
// Each accepted sample yields one fix (north, east, heading). The sample is worked through
// one shared bit-serial multiplier, one restoring divider and one iterative CORDIC (a
// sine/cosine pair per rotation). Encoder and inertial samples run in yaw-rate mode or in
// Euler mode, with one sample in flight at a time. A finished fix waits in the output
// register while the next sample is taken; the user is to write euler_mode through cfg_we
// and cfg_wdata while the block is idle, which the block itself does not enforce.
module dead_reckoning_navigator_core import drn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	drn_sample_if.sink  sample,
	drn_fix_if.source   fix
);
	typedef enum logic [5:0] {
		S_IDLE,
		S_ECR, S_ECP, S_EM1, S_EM2, S_EDIV, S_EM3, S_EM4, S_EM5, S_EM6, S_EM7,
		S_ESR_M, S_ESR_D, S_ESP_M, S_ESP_D, S_ESY_M, S_ESY_D, S_ESY_W,
		S_HM, S_HD,
		S_VFM, S_VFD, S_VSM, S_VSD,
		S_HCOR, S_PM1, S_PM2, S_PM3, S_PM4, S_PNM, S_PND, S_PEM, S_PED,
		S_PUSH
	} nav_state_t;

	nav_state_t state_q;
	nav_state_t nxt;
	logic issued_q;
	logic euler_q;

	logic kind_q;
	logic signed [31:0] speed_q, af_q, as_q, wx_q, wy_q, wz_q;
	logic [15:0] dt_q;

	logic signed [31:0] laf_q, las_q, vf_q, vs_q, lyr_q, heading_q;
	logic signed [31:0] roll_q, pitch_q, yaw_q;
	logic signed [47:0] pn_q, pe_q;

	logic signed [AW-1:0] ca_q, sa_q, cb_q, sb_q;
	logic signed [31:0] sum_q, sec_q, tn_q, dpsi_q, dphi_q, dth_q;
	logic signed [WW-1:0] t_q, prod_q, step_q;
	logic signed [MW-1:0] gn_q, ge_q;

	logic mul_start_q, div_start_q, cor_start_q;
	logic use_mul, use_div, use_cor, unit_done;
	logic signed [MW-1:0] mul_a, mul_b, u_w, v_w, dt_w;
	logic signed [WW-1:0] mul_p, div_sn, div_mag, fq, sec_w;
	logic [NW-1:0] div_q;
	logic [DW-1:0] div_d, div_r, fm;
	logic div_neg;
	logic signed [AW-1:0] cor_ang, cor_c, cor_s;
	logic mul_done, div_done, cor_done;

	assign sample.ready = (state_q == S_IDLE);

	assign dt_w = MW'(dt_q);
	assign u_w = kind_q ? MW'(vf_q) : MW'(speed_q);
	assign v_w = kind_q ? MW'(vs_q) : '0;

	always_comb begin
		use_mul = 1'b0;
		use_div = 1'b0;
		use_cor = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_sn = '0;
		div_d = DIV_MS;
		cor_ang = '0;
		nxt = S_IDLE;
		case (state_q)
			S_ECR: begin use_cor = 1'b1; cor_ang = AW'(roll_q) <<< 2; nxt = S_ECP; end
			S_ECP: begin use_cor = 1'b1; cor_ang = AW'(pitch_q) <<< 2; nxt = S_EM1; end
			S_EM1: begin use_mul = 1'b1; mul_a = MW'(wy_q); mul_b = MW'(sa_q); nxt = S_EM2; end
			S_EM2: begin use_mul = 1'b1; mul_a = MW'(wz_q); mul_b = MW'(ca_q); nxt = S_EDIV; end
			S_EDIV: begin
				use_div = 1'b1;
				div_sn = SEC_NUM;
				div_d = cb_q[AW-1] ? DW'(-cb_q) : DW'(cb_q);
				nxt = S_EM3;
			end
			S_EM3: begin use_mul = 1'b1; mul_a = MW'(sb_q); mul_b = MW'(sec_q); nxt = S_EM4; end
			S_EM4: begin use_mul = 1'b1; mul_a = MW'(sum_q); mul_b = MW'(sec_q); nxt = S_EM5; end
			S_EM5: begin use_mul = 1'b1; mul_a = MW'(sum_q); mul_b = MW'(tn_q); nxt = S_EM6; end
			S_EM6: begin use_mul = 1'b1; mul_a = MW'(wy_q); mul_b = MW'(ca_q); nxt = S_EM7; end
			S_EM7: begin use_mul = 1'b1; mul_a = MW'(wz_q); mul_b = MW'(sa_q); nxt = S_ESR_M; end
			S_ESR_M: begin use_mul = 1'b1; mul_a = MW'(dphi_q); mul_b = dt_w; nxt = S_ESR_D; end
			S_ESR_D: begin use_div = 1'b1; div_sn = (prod_q <<< 12) + HALF_MS; nxt = S_ESP_M; end
			S_ESP_M: begin use_mul = 1'b1; mul_a = MW'(dth_q); mul_b = dt_w; nxt = S_ESP_D; end
			S_ESP_D: begin use_div = 1'b1; div_sn = (prod_q <<< 12) + HALF_MS; nxt = S_ESY_M; end
			S_ESY_M: begin use_mul = 1'b1; mul_a = MW'(dpsi_q); mul_b = dt_w; nxt = S_ESY_D; end
			S_ESY_D: begin use_div = 1'b1; div_sn = (prod_q <<< 12) + HALF_MS; nxt = S_ESY_W; end
			S_ESY_W: begin
				use_div = 1'b1;
				div_sn = WW'(yaw_q) + step_q;
				div_d = TWO_PI_Q28;
				nxt = kind_q ? S_VFM : S_HCOR;
			end
			S_HM: begin
				use_mul = 1'b1;
				mul_a = MW'(lyr_q) + MW'(wz_q);
				mul_b = dt_w;
				nxt = S_HD;
			end
			S_HD: begin
				use_div = 1'b1;
				div_sn = (prod_q <<< 12) + HALF_TRAP;
				div_d = DIV_TRAP;
				nxt = kind_q ? S_VFM : S_HCOR;
			end
			S_VFM: begin
				use_mul = 1'b1;
				mul_a = MW'(laf_q) + MW'(af_q);
				mul_b = dt_w;
				nxt = S_VFD;
			end
			S_VFD: begin
				use_div = 1'b1;
				div_sn = prod_q + HALF_TRAP;
				div_d = DIV_TRAP;
				nxt = S_VSM;
			end
			S_VSM: begin
				use_mul = 1'b1;
				mul_a = MW'(las_q) + MW'(as_q);
				mul_b = dt_w;
				nxt = S_VSD;
			end
			S_VSD: begin
				use_div = 1'b1;
				div_sn = prod_q + HALF_TRAP;
				div_d = DIV_TRAP;
				nxt = S_HCOR;
			end
			S_HCOR: begin use_cor = 1'b1; cor_ang = AW'(heading_q) <<< 2; nxt = S_PM1; end
			S_PM1: begin use_mul = 1'b1; mul_a = MW'(ca_q); mul_b = u_w; nxt = S_PM2; end
			S_PM2: begin use_mul = 1'b1; mul_a = MW'(sa_q); mul_b = v_w; nxt = S_PM3; end
			S_PM3: begin use_mul = 1'b1; mul_a = MW'(sa_q); mul_b = u_w; nxt = S_PM4; end
			S_PM4: begin use_mul = 1'b1; mul_a = MW'(ca_q); mul_b = v_w; nxt = S_PNM; end
			S_PNM: begin use_mul = 1'b1; mul_a = gn_q; mul_b = dt_w; nxt = S_PND; end
			S_PND: begin use_div = 1'b1; div_sn = prod_q + HALF_MS; nxt = S_PEM; end
			S_PEM: begin use_mul = 1'b1; mul_a = ge_q; mul_b = dt_w; nxt = S_PED; end
			S_PED: begin use_div = 1'b1; div_sn = prod_q + HALF_MS; nxt = S_PUSH; end
			default: nxt = S_IDLE;
		endcase
	end

	assign div_neg = div_sn[WW-1];
	assign div_mag = div_neg ? -div_sn : div_sn;
	assign fq = floor_q(div_q, div_r, div_neg);
	assign fm = !div_neg ? div_r : ((div_r != '0) ? div_d - div_r : '0);
	assign sec_w = cb_q[AW-1] ? -WW'(div_q) : WW'(div_q);
	assign unit_done = use_mul ? mul_done : (use_div ? div_done : (use_cor && cor_done));

	drn_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q),
		.a(mul_a), .b(mul_b), .p(mul_p), .done(mul_done)
	);

	drn_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.n(div_mag[NW-1:0]), .d(div_d), .q(div_q), .r(div_r), .done(div_done)
	);

	drn_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start_q),
		.angle(cor_ang), .cos_v(cor_c), .sin_v(cor_s), .done(cor_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			euler_q <= 1'b0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			cor_start_q <= 1'b0;
			kind_q <= 1'b0;
			speed_q <= '0; af_q <= '0; as_q <= '0;
			wx_q <= '0; wy_q <= '0; wz_q <= '0; dt_q <= '0;
			laf_q <= '0; las_q <= '0; vf_q <= '0; vs_q <= '0;
			lyr_q <= '0; heading_q <= '0; roll_q <= '0; pitch_q <= '0; yaw_q <= '0;
			pn_q <= '0; pe_q <= '0;
			ca_q <= '0; sa_q <= '0; cb_q <= '0; sb_q <= '0;
			sum_q <= '0; sec_q <= '0; tn_q <= '0; dpsi_q <= '0; dphi_q <= '0; dth_q <= '0;
			t_q <= '0; prod_q <= '0; step_q <= '0; gn_q <= '0; ge_q <= '0;
			fix.valid <= 1'b0;
			fix.north <= '0;
			fix.east <= '0;
			fix.heading <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			cor_start_q <= 1'b0;
			if (cfg_we) begin
				euler_q <= cfg_wdata;
			end
			if (fix.valid && fix.ready) begin
				fix.valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						kind_q <= sample.req_type;
						speed_q <= sample.speed;
						af_q <= sample.accel_fwd;
						as_q <= sample.accel_side;
						wx_q <= sample.rate_x;
						wy_q <= sample.rate_y;
						wz_q <= sample.rate_z;
						dt_q <= sample.dt_ms;
						issued_q <= 1'b0;
						state_q <= euler_q ? S_ECR : S_HM;
					end
				end
				S_PUSH: begin
					if (!fix.valid || fix.ready) begin
						fix.valid <= 1'b1;
						fix.north <= pn_q;
						fix.east <= pe_q;
						fix.heading <= heading_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					if (state_q == S_EDIV && cb_q == '0) begin
						// A zero cosine gives the positive limit for the secant.
						sec_q <= {1'b0, {31{1'b1}}};
						state_q <= S_EM3;
					end else if (!issued_q) begin
						issued_q <= 1'b1;
						mul_start_q <= use_mul;
						div_start_q <= use_div;
						cor_start_q <= use_cor;
					end else if (unit_done) begin
						issued_q <= 1'b0;
						state_q <= nxt;
						if (use_mul) begin
							prod_q <= mul_p;
						end
						case (state_q)
							S_ECR: begin ca_q <= cor_c; sa_q <= cor_s; end
							S_ECP: begin cb_q <= cor_c; sb_q <= cor_s; end
							S_EM1: t_q <= mul_p;
							S_EM2: sum_q <= sat32(rshr(t_q + mul_p, 30));
							S_EDIV: sec_q <= sat32(sec_w);
							S_EM3: tn_q <= sat32(rshr(mul_p, 30));
							S_EM4: dpsi_q <= sat32(rshr(mul_p, 16));
							S_EM5: dphi_q <= sat32(WW'(wx_q) + rshr(mul_p, 16));
							S_EM6: t_q <= mul_p;
							S_EM7: dth_q <= sat32(rshr(t_q - mul_p, 30));
							S_ESR_D: roll_q <= sat32(WW'(roll_q) + fq);
							S_ESP_D: pitch_q <= sat32(WW'(pitch_q) + fq);
							S_ESY_D: step_q <= fq;
							S_ESY_W: begin
								yaw_q <= fm;
								heading_q <= fm;
							end
							S_HD: begin
								heading_q <= sat32(WW'(heading_q) + fq);
								lyr_q <= wz_q;
							end
							S_VFD: vf_q <= sat32(WW'(vf_q) + fq);
							S_VSD: begin
								vs_q <= sat32(WW'(vs_q) + fq);
								laf_q <= af_q;
								las_q <= as_q;
							end
							S_HCOR: begin ca_q <= cor_c; sa_q <= cor_s; end
							S_PM1: t_q <= mul_p;
							S_PM2: gn_q <= MW'(rshr(t_q - mul_p, 30));
							S_PM3: t_q <= mul_p;
							S_PM4: ge_q <= MW'(rshr(t_q + mul_p, 30));
							S_PND: pn_q <= sat48(WW'(pn_q) + fq);
							S_PED: pe_q <= sat48(WW'(pe_q) + fq);
							default: issued_q <= 1'b0;
						endcase
					end
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
			sample.valid && sample.ready |=> state_q != S_IDLE)
		else $error("accepted transaction did not start a computation");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == S_IDLE |-> !issued_q)
		else $error("unit request pending while idle");
	assert property (@(posedge clk) disable iff (!arst_n) mul_done |-> use_mul && issued_q)
		else $error("product returned to a step that did not request it");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> use_div && issued_q)
		else $error("quotient returned to a step that did not request it");
	assert property (@(posedge clk) disable iff (!arst_n)
			$rose(fix.valid) |-> $past(state_q) == S_PUSH)
		else $error("fix raised outside the output step");
endmodule
